FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose property is checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and codes shared by the best-fit allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int SIZE_W = 20;
    localparam int OFFS_W = 21;
    localparam int REQ_W  = 22;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic remove;
        logic insert;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_GRP,
        ST_TAKE,
        ST_INS,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/bfa_cell.sv
// ----------------------------------------------------------------------------
// bfa_cell
// One slot of the sorted free list; shifts left on remove, right on insert.
// ----------------------------------------------------------------------------
module bfa_cell #(
    parameter logic        INIT_VALID = 1'b0,
    parameter logic [19:0] INIT_SIZE  = 20'd0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfa_pkg::cell_ctrl_t           ctrl,
    input  logic [bfa_pkg::REQ_W-1:0]     req,
    input  bfa_pkg::entry_t               key,
    input  bfa_pkg::entry_t               left,
    input  logic                          left_less,
    input  logic                          left_fits,
    input  bfa_pkg::entry_t               right,
    output bfa_pkg::entry_t               cur,
    output logic                          less,
    output logic                          fits,
    output logic                          sel
);

    bfa_pkg::entry_t entry_reg;
    bfa_pkg::entry_t entry_next;

    assign cur  = entry_reg;
    // list is sorted by size then start, so fits is monotone along the row
    assign fits = entry_reg.valid && ({2'b00, entry_reg.size} >= req);
    assign sel  = fits && !left_fits;
    assign less = entry_reg.valid &&
                  ({entry_reg.size, entry_reg.start} <= {key.size, key.start});

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.remove)
        begin
            if (fits || !entry_reg.valid)
            begin
                entry_next = right;
            end
        end
        else if (ctrl.insert)
        begin
            if (!less)
            begin
                entry_next = left_less ? key : left;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= INIT_VALID;
            entry_reg.size  <= INIT_SIZE;
            entry_reg.start <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: rtl/bfa_reduce.sv
// ----------------------------------------------------------------------------
// bfa_reduce
// Two-stage registered OR tree that picks the selected cell's block.
// ----------------------------------------------------------------------------
module bfa_reduce #(
    parameter int N     = 1024,
    parameter int GROUP = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [N-1:0]                            sel,
    input  logic [2*bfa_pkg::SIZE_W-1:0]            data [N],
    output logic                                    found,
    output logic [2*bfa_pkg::SIZE_W-1:0]            best
);

    localparam int NG = (N + GROUP - 1) / GROUP;
    localparam int DW = 2 * bfa_pkg::SIZE_W;

    logic [DW-1:0] grp_data_reg [NG];
    logic [NG-1:0] grp_hit_reg;
    logic [DW-1:0] best_reg;
    logic          found_reg;

    logic [DW-1:0] grp_data_next [NG];
    logic [NG-1:0] grp_hit_next;
    logic [DW-1:0] best_next;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_data_next[g] = '0;
            grp_hit_next[g]  = 1'b0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < N)
                begin
                    grp_data_next[g] = grp_data_next[g] |
                                       ({DW{sel[g * GROUP + k]}} & data[g * GROUP + k]);
                    grp_hit_next[g]  = grp_hit_next[g] | sel[g * GROUP + k];
                end
            end
        end
    end

    always_comb
    begin
        best_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            best_next = best_next | grp_data_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        grp_data_reg <= grp_data_next;
        best_reg     <= best_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_hit_reg <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            grp_hit_reg <= grp_hit_next;
            found_reg   <= |grp_hit_reg;
        end
    end

    assign found = found_reg;
    assign best  = best_reg;

endmodule

FILE: rtl/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator with block splitting over a sorted chain of free cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries kind, size and offset; kind 0
// allocates, kind 1 frees. Output channel (out_valid/out_ready) returns one
// result per input: status, payload_offset and granted_size.
// The free list is a row of cells kept sorted by size then start, so the best
// fit is the first cell whose block is large enough. Removal shifts cells left
// and insertion shifts them right.
// An alloc goes from transfer to result register through select, the
// two-stage OR tree to read the chosen cell, remove and optional insert of
// the remainder; a free goes through an optional insert. One item is in
// work at a time, so a new input is taken only once the block is back in idle.
// Reset leaves one free block covering the arena after its header.
// If the receiver stalls, the result waits in the output register and the
// block holds its finished item until that register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_fit_block_allocator #(
    parameter int FREE_ENTRIES = 1024,
    parameter int ARENA_BYTES  = 1048576,
    parameter int HEADER_BYTES = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [bfa_pkg::OFFS_W-1:0]    size,
    input  logic [bfa_pkg::OFFS_W-1:0]    offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [bfa_pkg::OFFS_W-1:0]    payload_offset,
    output logic [bfa_pkg::SIZE_W-1:0]    granted_size
);

    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int SW    = bfa_pkg::SIZE_W;
    localparam int OW    = bfa_pkg::OFFS_W;
    localparam int RW    = bfa_pkg::REQ_W;
    localparam logic [SW-1:0]    INIT_SIZE = SW'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [OW-1:0]    HDR_O     = OW'(HEADER_BYTES);
    localparam logic [RW-1:0]    HDR_R     = RW'(HEADER_BYTES);
    localparam logic [OW-1:0]    ARENA_O   = OW'(ARENA_BYTES);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FREE_ENTRIES);

    bfa_pkg::state_t state_reg, state_next;

    logic [RW-1:0]      req_reg;
    bfa_pkg::entry_t    key_reg;
    logic [1:0]         status_reg;
    logic [OW-1:0]      pay_reg;
    logic [SW-1:0]      gr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [OW-1:0]      out_pay_reg;
    logic [SW-1:0]      out_gr_reg;

    bfa_pkg::cell_ctrl_t ctrl;
    logic               out_load;

    // cell row
    bfa_pkg::entry_t    cur  [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0] less_v, fits_v, sel_v;
    logic [2*SW-1:0]    cell_data [FREE_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < FREE_ENTRIES; gi++)
        begin : g_cell
            bfa_pkg::entry_t left_e, right_e;
            logic left_less, left_fits;
            if (gi == 0)
            begin : g_first
                assign left_e    = '0;
                assign left_less = 1'b1;
                assign left_fits = 1'b0;
            end
            else
            begin : g_mid
                assign left_e    = cur[gi-1];
                assign left_less = less_v[gi-1];
                assign left_fits = fits_v[gi-1];
            end
            if (gi == FREE_ENTRIES - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_next
                assign right_e = cur[gi+1];
            end

            bfa_cell #(
                .INIT_VALID (gi == 0),
                .INIT_SIZE  ((gi == 0) ? INIT_SIZE : '0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .req       (req_reg),
                .key       (key_reg),
                .left      (left_e),
                .left_less (left_less),
                .left_fits (left_fits),
                .right     (right_e),
                .cur       (cur[gi]),
                .less      (less_v[gi]),
                .fits      (fits_v[gi]),
                .sel       (sel_v[gi])
            );
            assign cell_data[gi] = {cur[gi].size, cur[gi].start};
        end
    endgenerate

    logic            found;
    logic [2*SW-1:0] best;

    bfa_reduce #(
        .N     (FREE_ENTRIES),
        .GROUP (32)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .sel   (sel_v),
        .data  (cell_data),
        .found (found),
        .best  (best)
    );

    logic [SW-1:0] best_size, best_start;
    assign best_size  = best[2*SW-1:SW];
    assign best_start = best[SW-1:0];

    // input decode
    logic [RW-1:0] req_round;
    logic [OW-1:0] off_sub;
    logic          free_ok;
    logic [SW-1:0] free_size;
    assign req_round = ({1'b0, size} + RW'(7)) & ~RW'(7);
    assign off_sub   = offset - HDR_O;
    assign free_ok   = (offset >= HDR_O) && (offset != '0) && (off_sub < ARENA_O);
    assign free_size = size[OW-1] ? {SW{1'b1}} : size[SW-1:0];

    // split of the chosen block
    logic          split;
    assign split = {2'b00, best_size} > (req_reg + HDR_R);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == bfa_pkg::KIND_ALLOC)
                        state_next = bfa_pkg::ST_SEL;
                    else if (free_ok && count_reg != FULL_CNT)
                        state_next = bfa_pkg::ST_INS;
                    else
                        state_next = bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_SEL:  state_next = bfa_pkg::ST_GRP;
            bfa_pkg::ST_GRP:  state_next = bfa_pkg::ST_TAKE;
            bfa_pkg::ST_TAKE: state_next = (found && split) ? bfa_pkg::ST_INS
                                                            : bfa_pkg::ST_DONE;
            bfa_pkg::ST_INS:  state_next = bfa_pkg::ST_DONE;
            bfa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = bfa_pkg::ST_IDLE;
            end
            default:          state_next = bfa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == bfa_pkg::ST_IDLE);
        ctrl.remove = (state_reg == bfa_pkg::ST_TAKE) && found;
        ctrl.insert = (state_reg == bfa_pkg::ST_INS);
        out_load    = (state_reg == bfa_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::ST_IDLE;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.remove && !ctrl.insert)
                count_reg <= count_reg - CNT_W'(1);
            else if (ctrl.insert)
                count_reg <= count_reg + CNT_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg       <= req_round;
            key_reg.valid <= 1'b1;
            key_reg.size  <= free_size;
            key_reg.start <= off_sub[SW-1:0];
            pay_reg       <= '0;
            gr_reg        <= '0;
            if (kind == bfa_pkg::KIND_FREE && free_ok && count_reg == FULL_CNT)
                status_reg <= bfa_pkg::STATUS_FULL;
            else
                status_reg <= bfa_pkg::STATUS_OK;
        end
        else if (state_reg == bfa_pkg::ST_TAKE)
        begin
            if (!found)
            begin
                status_reg <= bfa_pkg::STATUS_NOFIT;
            end
            else
            begin
                pay_reg       <= {1'b0, best_start} + HDR_O;
                gr_reg        <= split ? req_reg[SW-1:0] : best_size;
                // remainder after the granted payload
                key_reg.valid <= 1'b1;
                key_reg.size  <= best_size - req_reg[SW-1:0] - HDR_R[SW-1:0];
                key_reg.start <= best_start + HDR_R[SW-1:0] + req_reg[SW-1:0];
            end
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_pay_reg    <= pay_reg;
            out_gr_reg     <= gr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign payload_offset = out_pay_reg;
    assign granted_size   = out_gr_reg;

    `ASSERT_CLK(a_count_range, clk, rst_n, count_reg <= FULL_CNT, "free count above table size")
    `ASSERT_CLK(a_remove_nonempty, clk, rst_n, !ctrl.remove || count_reg != '0,
                "remove from empty free list")
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready,
                 "new transfer taken while item in work")
    `ASSERT_CLK(a_insert_not_full, clk, rst_n, !ctrl.insert || count_reg != FULL_CNT,
                "insert into full free list")

endmodule

FILE: tb/tb_best_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Drives alloc and free requests with random gaps and output stalls, predicts
// each result from a private copy of the free table and compares in order.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator;

    localparam int FREE_ENTRIES = 1024;
    localparam int ARENA_BYTES  = 1048576;
    localparam int HEADER_BYTES = 24;
    localparam int IDLE_LIMIT   = 400;

    typedef struct {
        logic [1:0]                 status;
        logic [bfa_pkg::OFFS_W-1:0] payload_offset;
        logic [bfa_pkg::SIZE_W-1:0] granted_size;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [bfa_pkg::SIZE_W-1:0] blk_size [FREE_ENTRIES];
        logic [bfa_pkg::SIZE_W-1:0] blk_start[FREE_ENTRIES];
        int unsigned                blk_count;
        alloc_result_t              pending_results[$];
        int unsigned                errors;

        function new();
            blk_size[0]  = bfa_pkg::SIZE_W'(ARENA_BYTES - HEADER_BYTES);
            blk_start[0] = '0;
            blk_count    = 1;
            errors       = 0;
        endfunction

        function bit add_block(int unsigned start, int unsigned sz);
            if (blk_count >= FREE_ENTRIES)
                return 0;
            blk_start[blk_count] = bfa_pkg::SIZE_W'(start);
            blk_size[blk_count]  = bfa_pkg::SIZE_W'(sz);
            blk_count++;
            return 1;
        endfunction

        // predicts the result of an accepted request and queues it
        function alloc_result_t note_request(logic k, logic [bfa_pkg::OFFS_W-1:0] sz,
                                             logic [bfa_pkg::OFFS_W-1:0] off);
            alloc_result_t r;
            int unsigned req, bstart, bsize;
            int best;
            r = '{bfa_pkg::STATUS_OK, '0, '0};
            if (k == bfa_pkg::KIND_ALLOC) begin
                req  = (int'(sz) + 7) & ~7;
                best = -1;
                for (int i = 0; i < blk_count; i++) begin
                    if (blk_size[i] >= req && (best < 0 || blk_size[i] < blk_size[best] ||
                        (blk_size[i] == blk_size[best] && blk_start[i] < blk_start[best])))
                        best = i;
                end
                if (best < 0) begin
                    r.status = bfa_pkg::STATUS_NOFIT;
                end else begin
                    bstart = blk_start[best];
                    bsize  = blk_size[best];
                    blk_count--;
                    blk_start[best] = blk_start[blk_count];
                    blk_size[best]  = blk_size[blk_count];
                    if (bsize > req + HEADER_BYTES) begin
                        void'(add_block(bstart + HEADER_BYTES + req,
                                        bsize - req - HEADER_BYTES));
                        r.granted_size = bfa_pkg::SIZE_W'(req);
                    end else begin
                        r.granted_size = bfa_pkg::SIZE_W'(bsize);
                    end
                    r.payload_offset = bfa_pkg::OFFS_W'(bstart + HEADER_BYTES);
                end
            end else if (off >= HEADER_BYTES && off - HEADER_BYTES < ARENA_BYTES) begin
                if (!add_block(off - HEADER_BYTES, sz > 21'hFFFFF ? 21'hFFFFF : sz))
                    r.status = bfa_pkg::STATUS_FULL;
            end
            pending_results.push_back(r);
            return r;
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0d size=%0d",
                         $time, got.status, got.payload_offset, got.granted_size);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.payload_offset !== exp.payload_offset) begin
                $display("%0t: payload_offset expected %0d got %0d", $time,
                         exp.payload_offset, got.payload_offset);
                errors++;
            end
            if (got.granted_size !== exp.granted_size) begin
                $display("%0t: granted_size expected %0d got %0d", $time,
                         exp.granted_size, got.granted_size);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       kind = bfa_pkg::KIND_ALLOC;
    logic [bfa_pkg::OFFS_W-1:0] size = '0;
    logic [bfa_pkg::OFFS_W-1:0] offset = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 status;
    logic [bfa_pkg::OFFS_W-1:0] payload_offset;
    logic [bfa_pkg::SIZE_W-1:0] granted_size;

    alloc_scoreboard            sb = new();
    logic [bfa_pkg::OFFS_W-1:0] live_offs[$];
    logic [bfa_pkg::OFFS_W-1:0] live_sizes[$];
    int unsigned                idle_cycles = 0;

    best_fit_block_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .size(size), .offset(offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .payload_offset(payload_offset), .granted_size(granted_size)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one request: random gap, then hold valid until the transfer
    task automatic send_request(logic k, logic [bfa_pkg::OFFS_W-1:0] sz,
                                logic [bfa_pkg::OFFS_W-1:0] off);
        int gap;
        alloc_result_t r;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        size     <= sz;
        offset   <= off;
        do @(posedge clk); while (!(in_valid && in_ready));
        r = sb.note_request(k, sz, off);
        if (k == bfa_pkg::KIND_ALLOC && r.status == bfa_pkg::STATUS_OK) begin
            live_offs.push_back(r.payload_offset);
            live_sizes.push_back(bfa_pkg::OFFS_W'(r.granted_size));
        end
    endtask

    task automatic alloc_req(logic [bfa_pkg::OFFS_W-1:0] sz);
        send_request(bfa_pkg::KIND_ALLOC, sz, bfa_pkg::OFFS_W'($urandom));
    endtask

    task automatic free_live();
        int idx;
        logic [bfa_pkg::OFFS_W-1:0] o, s;
        if (live_offs.size() == 0) begin
            alloc_req(bfa_pkg::OFFS_W'($urandom_range(0, 512)));
            return;
        end
        idx = $urandom_range(0, live_offs.size() - 1);
        o = live_offs[idx];
        s = live_sizes[idx];
        live_offs.delete(idx);
        live_sizes.delete(idx);
        send_request(bfa_pkg::KIND_FREE, s, o);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic random_mix(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                alloc_req(bfa_pkg::OFFS_W'($urandom_range(0, 600)));
            else if (pick < 50)
                alloc_req(bfa_pkg::OFFS_W'($urandom_range(0, 21'h1FFFFF)));
            else if (pick < 53)
                alloc_req(bfa_pkg::OFFS_W'($urandom_range(0, 200000)));
            else if (pick < 90)
                free_live();
            else
                send_request(bfa_pkg::KIND_FREE, bfa_pkg::OFFS_W'($urandom),
                             bfa_pkg::OFFS_W'($urandom));
        end
    endtask

    // result side: random stall before each transfer
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{status, payload_offset, granted_size});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero and tiny requests, too large, near fit, odd frees
        alloc_req(21'd0);
        alloc_req(21'd1);
        alloc_req(21'd8);
        alloc_req(21'h1FFFFF);
        alloc_req(21'd1048576);
        send_request(bfa_pkg::KIND_FREE, 21'd64, 21'd0);
        send_request(bfa_pkg::KIND_FREE, 21'd64, 21'd8);
        send_request(bfa_pkg::KIND_FREE, 21'd64, 21'd23);
        send_request(bfa_pkg::KIND_FREE, 21'd64, 21'h1FFFFF);
        send_request(bfa_pkg::KIND_FREE, 21'd64, 21'd1048600);
        send_request(bfa_pkg::KIND_FREE, 21'h1FFFFF, 21'd1048599);
        send_request(bfa_pkg::KIND_FREE, 21'd32, 21'd24);
        alloc_req(21'd16);
        send_request(bfa_pkg::KIND_FREE, 21'd48, 21'd100024);
        alloc_req(21'd24);
        alloc_req(21'd1048000);
        free_live();
        free_live();
        alloc_req(21'd1048552);
        alloc_req(21'd7);
        free_live();
        drain();

        random_mix(500);
        drain();

        // fill the free table with bogus blocks, then keep pushing frees
        repeat (1080) begin
            if ($urandom_range(0, 9) == 0)
                alloc_req(bfa_pkg::OFFS_W'($urandom_range(0, 300)));
            else
                send_request(bfa_pkg::KIND_FREE, bfa_pkg::OFFS_W'($urandom_range(0, 2000)),
                             bfa_pkg::OFFS_W'($urandom_range(HEADER_BYTES,
                                                             ARENA_BYTES + 23)));
        end
        random_mix(150);
        drain();

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
